// ===== hdl/ofw_pkg.sv =====
// ============================================================================
// Overlapping frame windower package
// Shared constants, codes, control structs and arithmetic helpers.
// ============================================================================
package ofw_pkg;

    // Build-time limits.
    localparam int MAX_FRAME   = 64;
    localparam int SAMPLE_BITS = 16;

    // Index width into the sample ring and the window table.
    localparam int PTR_W = $clog2(MAX_FRAME);

    // Field widths.
    localparam int OP_W      = 2;
    localparam int SMP_W     = 16;
    localparam int CIDX_W    = 6;
    localparam int COEF_W    = 16;
    localparam int POS_W     = 6;
    localparam int FNUM_W    = 16;
    localparam int LEN_W     = 7;
    localparam int HOP_W     = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    // Product of a signed sample and a zero-extended coefficient.
    localparam int PROD_W    = SMP_W + COEF_W + 1;
    localparam int COEF_FRAC = 15;

    // Width to which an incoming sample is reduced before sign extension.
    localparam int RED_BITS = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_SIZE   = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0] FRAME_SIZE_RST = 7'd64;
    localparam logic [HOP_W-1:0] HOP_SIZE_RST   = 12'd16;

    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(2 ** (SMP_W - 1) - 1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(2 ** (SMP_W - 1));

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // a request is taken this cycle
        logic read;     // read ring and window at the current frame position
        logic mul;      // register the product of the read data
        logic put;      // load the output register and advance the position
    } ofw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;     // the request on the input starts a frame
        logic last;     // the product in flight is the final one of its frame
        logic out_free; // the output register can take a value this cycle
    } ofw_status_t;

    // Reduce a sample to SAMPLE_BITS and sign-extend it back to full width.
    function automatic logic signed [SMP_W-1:0] reduce_sample(input logic [SMP_W-1:0] s);
        logic signed [RED_BITS-1:0] low;
        low = s[RED_BITS-1:0];
        return SMP_W'(low);
    endfunction

    // Floor division by 2^15 followed by saturation to the sample range.
    function automatic logic signed [SMP_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = p >>> COEF_FRAC;
        if (q > SAT_MAX)
        begin
            return SAT_MAX[SMP_W-1:0];
        end
        else if (q < SAT_MIN)
        begin
            return SAT_MIN[SMP_W-1:0];
        end
        return q[SMP_W-1:0];
    endfunction

endpackage

// ===== hdl/ofw_stream_if.sv =====
// ============================================================================
// Overlapping frame windower stream interfaces
// Valid/ready channels for incoming requests and outgoing windowed values.
// ============================================================================
interface ofw_item_if import ofw_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [SMP_W-1:0]  sample;
    logic [CIDX_W-1:0]        coef_index;
    logic [COEF_W-1:0]        coef_value;

    modport source (output valid, output op, output sample, output coef_index,
                    output coef_value, input ready);
    modport sink   (input valid, input op, input sample, input coef_index,
                    input coef_value, output ready);
endinterface

interface ofw_result_if import ofw_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  windowed_value;
    logic [POS_W-1:0]         position;
    logic [FNUM_W-1:0]        frame_number;
    logic                     last_of_frame;

    modport source (output valid, output windowed_value, output position,
                    output frame_number, output last_of_frame, input ready);
    modport sink   (input valid, input windowed_value, input position,
                    input frame_number, input last_of_frame, output ready);
endinterface

// ===== hdl/ofw_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module ofw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/ofw_ctrl.sv =====
// ============================================================================
// Overlapping frame windower controller
// Sequences request acceptance and the read, multiply and output steps.
// ============================================================================
module ofw_ctrl import ofw_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ofw_status_t status,
    output ofw_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.emit)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.put    = 1'b1;
                    state_next = status.last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/ofw_datapath.sv =====
// ============================================================================
// Overlapping frame windower datapath
// Sample ring, window table, framing counters, multiplier and output stage.
// ============================================================================
module ofw_datapath import ofw_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ofw_cmd_t                cmd,
    output ofw_status_t             status,
    input  logic [OP_W-1:0]         op,
    input  logic signed [SMP_W-1:0] sample,
    input  logic [CIDX_W-1:0]       coef_index,
    input  logic [COEF_W-1:0]       coef_value,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic signed [SMP_W-1:0] windowed_value,
    output logic [POS_W-1:0]        position,
    output logic [FNUM_W-1:0]       frame_number,
    output logic                    last_of_frame
);

    // Configuration and stream state.
    logic [LEN_W-1:0]  frame_size_reg;
    logic [HOP_W-1:0]  hop_size_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [HOP_W-1:0]  hop_cd_reg;
    logic [FNUM_W-1:0] frames_reg;

    // Frame walk.
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [FNUM_W-1:0] fnum_reg;

    // Multiply stage.
    logic signed [PROD_W-1:0] prod_reg;
    logic [PTR_W-1:0]         mpos_reg;
    logic                     mlast_reg;

    // Output stage.
    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] out_value_reg;
    logic [POS_W-1:0]        out_pos_reg;
    logic [FNUM_W-1:0]       out_fnum_reg;
    logic                    out_last_reg;

    logic [LEN_W-1:0]  eff_len;
    logic [HOP_W-1:0]  eff_hop;
    logic [LEN_W-1:0]  fill_inc;
    logic [HOP_W-1:0]  cd_dec;
    logic              emit_now;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [PTR_W:0]    base_sum;
    logic [PTR_W-1:0]  base;
    logic              is_sample;
    logic              coef_ok;

    logic [SMP_W-1:0]         ring_q;
    logic [COEF_W-1:0]        win_q;
    logic signed [SMP_W-1:0]  ring_s;
    logic signed [COEF_W:0]   coef_s;

    assign is_sample = (op == OP_SAMPLE);
    assign coef_ok   = ({1'b0, coef_index} < (CIDX_W + 1)'(MAX_FRAME));

    // Frame length clamped to 1..MAX_FRAME, hop of zero taken as one.
    always_comb
    begin
        if (frame_size_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (frame_size_reg > LEN_W'(MAX_FRAME))
        begin
            eff_len = LEN_W'(MAX_FRAME);
        end
        else
        begin
            eff_len = frame_size_reg;
        end
    end

    assign eff_hop  = (hop_size_reg == '0) ? HOP_W'(1) : hop_size_reg;
    assign fill_inc = (fill_reg < LEN_W'(MAX_FRAME)) ? fill_reg + LEN_W'(1) : fill_reg;
    assign cd_dec   = hop_cd_reg - HOP_W'(1);

    // A frame is due when the hop runs out (or none has been sent yet) and
    // enough samples have arrived since the stream was restarted.
    assign emit_now = ((hop_cd_reg == '0) || (cd_dec == '0)) && (fill_inc >= eff_len);

    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(MAX_FRAME - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(MAX_FRAME - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    // Oldest sample of the frame, counted back from the slot after this sample.
    assign base_sum = (PTR_W + 1)'(wr_ptr_inc) + (PTR_W + 1)'(MAX_FRAME)
                    - (PTR_W + 1)'(eff_len);
    assign base     = (base_sum >= (PTR_W + 1)'(MAX_FRAME))
                    ? PTR_W'(base_sum - (PTR_W + 1)'(MAX_FRAME))
                    : PTR_W'(base_sum);

    assign status.emit     = is_sample && emit_now;
    assign status.last     = mlast_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    ofw_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_FRAME)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.accept && is_sample),
        .wr_addr (wr_ptr_reg),
        .wr_data (reduce_sample(sample)),
        .rd_en   (cmd.read),
        .rd_addr (rd_ptr_reg),
        .rd_data (ring_q)
    );

    ofw_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_FRAME)
    ) u_window (
        .clk     (clk),
        .wr_en   (cmd.accept && (op == OP_COEF) && coef_ok),
        .wr_addr (coef_index[PTR_W-1:0]),
        .wr_data (coef_value),
        .rd_en   (cmd.read),
        .rd_addr (pos_reg),
        .rd_data (win_q)
    );

    assign ring_s = ring_q;
    assign coef_s = {1'b0, win_q};

    // Configuration and stream counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= FRAME_SIZE_RST;
            hop_size_reg   <= HOP_SIZE_RST;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
            hop_cd_reg     <= '0;
            frames_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_SIZE: frame_size_reg <= cfg_data[LEN_W-1:0];
                    REG_HOP_SIZE:   hop_size_reg   <= cfg_data[HOP_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.accept)
            begin
                case (op)
                    OP_SAMPLE:
                    begin
                        wr_ptr_reg <= wr_ptr_inc;
                        fill_reg   <= fill_inc;
                        if (emit_now)
                        begin
                            hop_cd_reg <= eff_hop;
                            frames_reg <= frames_reg + FNUM_W'(1);
                        end
                        else if (hop_cd_reg != '0)
                        begin
                            hop_cd_reg <= cd_dec;
                        end
                    end
                    OP_RESTART:
                    begin
                        wr_ptr_reg <= '0;
                        fill_reg   <= '0;
                        hop_cd_reg <= '0;
                        frames_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Frame walk and multiply stage.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.emit)
        begin
            rd_ptr_reg <= base;
            pos_reg    <= '0;
            len_reg    <= eff_len;
            fnum_reg   <= frames_reg;
        end
        else if (cmd.put)
        begin
            rd_ptr_reg <= rd_ptr_inc;
            pos_reg    <= pos_reg + PTR_W'(1);
        end
        if (cmd.mul)
        begin
            prod_reg  <= ring_s * coef_s;
            mpos_reg  <= pos_reg;
            mlast_reg <= (LEN_W'(pos_reg) == len_reg - LEN_W'(1));
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            out_value_reg <= saturate(prod_reg);
            out_pos_reg   <= POS_W'(mpos_reg);
            out_fnum_reg  <= fnum_reg;
            out_last_reg  <= mlast_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign windowed_value = out_value_reg;
    assign position       = out_pos_reg;
    assign frame_number   = out_fnum_reg;
    assign last_of_frame  = out_last_reg;

endmodule

// ===== hdl/overlapping_frame_windower.sv =====
// ============================================================================
// Overlapping frame windower
// Frames a sample stream into overlapping windows and weights each sample.
// ============================================================================
// Requests arrive on the items channel: an audio sample, a window coefficient
// load or a stream restart. Windowed values leave on the results channel,
// oldest sample of the frame first, with the final value of each frame marked.
// Frame size and hop size are written through the plain cfg write port; the
// user must write them only while the block is idle; the block does not enforce it.
//
// A request that starts no frame is taken and leaves the controller idle. A sample
// that completes a frame holds the items channel off while the frame is sent:
// each value passes through a registered read of the ring and window RAMs,
// a registered multiply, then the output register, and the walk moves on to
// the next value only once the output register can take the current one.
//
// A stall on the results channel holds the current value in the output
// register and freezes the frame walk; the next request can already be taken
// while the final value of a frame still waits. Reset clears the stream
// counters and restores frame size 64 and hop size 16; the window table and
// sample ring keep no reset values, so the window must be loaded after reset.
// ============================================================================
module overlapping_frame_windower import ofw_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    ofw_item_if.sink              items,
    ofw_result_if.source          results,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    ofw_cmd_t    cmd;
    ofw_status_t status;
    logic        in_ready;

    // The controller owns the handshake and sequences each frame.
    ofw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign items.ready = in_ready;

    // The datapath keeps the ring, the window table, the counters and the
    // output register.
    ofw_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .op             (items.op),
        .sample         (items.sample),
        .coef_index     (items.coef_index),
        .coef_value     (items.coef_value),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (results.ready),
        .out_valid      (results.valid),
        .windowed_value (results.windowed_value),
        .position       (results.position),
        .frame_number   (results.frame_number),
        .last_of_frame  (results.last_of_frame)
    );

endmodule

// ===== hdl/ofw_checker.sv =====
// ============================================================================
// Overlapping frame windower checker
// Port-level properties of the results channel and its tie to the input.
// ============================================================================
module ofw_checker import ofw_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [SMP_W-1:0] windowed_value,
    input logic [POS_W-1:0]        position,
    input logic [FNUM_W-1:0]       frame_number,
    input logic                    last_of_frame
);

    // A stalled value stays on the channel unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(windowed_value)
            && $stable(position) && $stable(frame_number) && $stable(last_of_frame))
        else $error("results changed while stalled");

    // A value is withdrawn only after it was taken.
    a_drop_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without being taken");

    // While a frame is under way no new request is taken.
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_frame |-> !in_ready)
        else $error("request taken in the middle of a frame");

    // The highest position can only be the end of a full-size frame.
    a_top_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (position == POS_W'(MAX_FRAME - 1)) |-> last_of_frame)
        else $error("top position not marked as last");

endmodule

bind overlapping_frame_windower ofw_checker u_ofw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (items.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .windowed_value (results.windowed_value),
    .position       (results.position),
    .frame_number   (results.frame_number),
    .last_of_frame  (results.last_of_frame)
);
